@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the timer RTL.
// Each macro expands to one labelled concurrent assertion that is disabled
// while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising clock edge out of reset.
`define CDT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define CDT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg
// Types, constants and small helper functions of the countdown timer.
// ----------------------------------------------------------------------------
package cdt_pkg;

    typedef enum logic [1:0] {
        OP_KEY_POLL   = 2'd0,
        OP_BASE_TICK  = 2'd1,
        OP_BLINK_TICK = 2'd2,
        OP_SCAN       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_SEC  = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_HOUR = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [1:0] CFG_BLINK_DIVIDE     = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_POLLS   = 2'd2;

    localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd20;
    localparam logic [7:0] BLINK_DIVIDE_RST     = 8'd13;
    localparam logic [7:0] DEBOUNCE_POLLS_RST   = 8'd3;

    // Scan positions.
    localparam logic [2:0] DIG_SEC_ONES  = 3'd0;
    localparam logic [2:0] DIG_SEC_TENS  = 3'd1;
    localparam logic [2:0] DIG_DASH_LO   = 3'd2;
    localparam logic [2:0] DIG_MIN_ONES  = 3'd3;
    localparam logic [2:0] DIG_MIN_TENS  = 3'd4;
    localparam logic [2:0] DIG_DASH_HI   = 3'd5;
    localparam logic [2:0] DIG_HOUR_ONES = 3'd6;
    localparam logic [2:0] DIG_HOUR_TENS = 3'd7;

    localparam logic [6:0] SEC_MAX  = 7'd59;
    localparam logic [6:0] MIN_MAX  = 7'd59;
    localparam logic [6:0] HOUR_MAX = 7'd99;
    localparam logic [7:0] SEG_DASH = 8'h40;
    localparam logic [7:0] DEBOUNCE_SAT = 8'd255;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [7:0] blink_divide;
        logic [7:0] debounce_polls;
    } cfg_t;

    typedef struct packed {
        logic [5:0] sec_count;
        logic [5:0] min_count;
        logic [6:0] hour_count;
        logic       run_flag;
        mode_t      mode;
        logic [2:0] blank_flags;
        logic       blink_enable;
        logic [7:0] debounce_count;
        logic       key_lock;
        logic [7:0] second_prescale;
        logic [7:0] blink_prescale;
    } timer_state_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] count;
    } debounce_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } decimal_t;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [6:0] hours;
        logic       running;
        logic [1:0] edit_mode;
        logic [7:0] segments;
    } result_t;

    function automatic logic time_is_zero(input timer_state_t st);
        return (st.sec_count == 6'd0) && (st.min_count == 6'd0) && (st.hour_count == 7'd0);
    endfunction

    // One pressed key: the count saturates, and a hit clears it.
    function automatic debounce_t debounce_step(input logic [7:0] count,
                                                input logic [7:0] limit);
        debounce_t r;
        r.count = (count < DEBOUNCE_SAT) ? count + 8'd1 : count;
        r.hit   = (r.count > limit);
        if (r.hit)
        begin
            r.count = 8'd0;
        end
        return r;
    endfunction

    function automatic logic [6:0] wrap_dec(input logic [6:0] value, input logic [6:0] top);
        return (value == 7'd0) ? top : value - 7'd1;
    endfunction

    function automatic logic [6:0] wrap_inc(input logic [6:0] value, input logic [6:0] top);
        return (value >= top) ? 7'd0 : value + 7'd1;
    endfunction

    // Blank flag belonging to the field being edited; none in mode 0.
    function automatic logic [2:0] mode_mask(input mode_t mode);
        logic [2:0] m;
        unique case (mode)
            MODE_NONE: m = 3'b000;
            MODE_SEC:  m = 3'b001;
            MODE_MIN:  m = 3'b010;
            MODE_HOUR: m = 3'b100;
            default:   m = 3'b000;
        endcase
        return m;
    endfunction

    // Tens by multiplication with a reciprocal, exact for all 7-bit values.
    function automatic decimal_t split_decimal(input logic [6:0] value);
        decimal_t   d;
        logic [14:0] prod;
        logic [6:0]  rem;
        prod   = 15'(value) * 15'd205;
        d.tens = prod[14:11];
        rem    = value - {d.tens, 3'b000} - {2'b00, d.tens, 1'b0};
        d.ones = rem[3:0];
        return d;
    endfunction

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] s;
        unique case (digit)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/cdt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_if
// Valid/ready channels carrying timer events in and timer results out.
// ----------------------------------------------------------------------------
interface cdt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] key_levels;
    logic [2:0] digit_index;

    modport source (output valid, output opcode, output key_levels, output digit_index,
                    input ready);
    modport sink (input valid, input opcode, input key_levels, input digit_index,
                  output ready);
endinterface

interface cdt_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [6:0] hours;
    logic       running;
    logic [1:0] edit_mode;
    logic [7:0] segments;

    modport source (output valid, output seconds, output minutes, output hours,
                    output running, output edit_mode, output segments, input ready);
    modport sink (input valid, input seconds, input minutes, input hours,
                  input running, input edit_mode, input segments, output ready);
endinterface

@@ rtl/core/cdt_state.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_state
// Timer state register with its next-state logic for key polls and ticks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdt_state
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   upd_en,
    input  cdt_pkg::op_t           op,
    input  logic [3:0]             key_levels,
    input  cdt_pkg::cfg_t          cfg,
    output cdt_pkg::timer_state_t  state_next
);

    cdt_pkg::timer_state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (upd_en)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cdt_pkg::timer_state_t s;
        cdt_pkg::debounce_t    r;
        s = state_reg;
        r = '0;
        if (upd_en)
        begin
            unique case (op)
                cdt_pkg::OP_KEY_POLL:
                begin
                    // Keys are taken in order; the first accepted one locks the rest.
                    if (!s.key_lock && !key_levels[0])
                    begin
                        r = cdt_pkg::debounce_step(s.debounce_count, cfg.debounce_polls);
                        s.debounce_count = r.count;
                        s.key_lock = r.hit;
                        if (r.hit && !cdt_pkg::time_is_zero(s) && s.mode == cdt_pkg::MODE_NONE)
                        begin
                            s.run_flag = !s.run_flag;
                        end
                    end
                    if (!s.key_lock && !key_levels[1])
                    begin
                        r = cdt_pkg::debounce_step(s.debounce_count, cfg.debounce_polls);
                        s.debounce_count = r.count;
                        s.key_lock = r.hit;
                        if (r.hit)
                        begin
                            if (!cdt_pkg::time_is_zero(s) && s.mode == cdt_pkg::MODE_NONE
                                && !s.run_flag)
                            begin
                                s.sec_count  = 6'd0;
                                s.min_count  = 6'd0;
                                s.hour_count = 7'd0;
                            end
                            else
                            begin
                                unique case (s.mode)
                                    cdt_pkg::MODE_SEC:
                                        s.sec_count = 6'(cdt_pkg::wrap_dec({1'b0, s.sec_count},
                                                                           cdt_pkg::SEC_MAX));
                                    cdt_pkg::MODE_MIN:
                                        s.min_count = 6'(cdt_pkg::wrap_dec({1'b0, s.min_count},
                                                                           cdt_pkg::MIN_MAX));
                                    cdt_pkg::MODE_HOUR:
                                        s.hour_count = cdt_pkg::wrap_dec(s.hour_count,
                                                                         cdt_pkg::HOUR_MAX);
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                    if (!s.key_lock && !key_levels[2])
                    begin
                        r = cdt_pkg::debounce_step(s.debounce_count, cfg.debounce_polls);
                        s.debounce_count = r.count;
                        s.key_lock = r.hit;
                        if (r.hit && !s.run_flag)
                        begin
                            unique case (s.mode)
                                cdt_pkg::MODE_SEC:
                                    s.sec_count = 6'(cdt_pkg::wrap_inc({1'b0, s.sec_count},
                                                                       cdt_pkg::SEC_MAX));
                                cdt_pkg::MODE_MIN:
                                    s.min_count = 6'(cdt_pkg::wrap_inc({1'b0, s.min_count},
                                                                       cdt_pkg::MIN_MAX));
                                cdt_pkg::MODE_HOUR:
                                    s.hour_count = cdt_pkg::wrap_inc(s.hour_count,
                                                                     cdt_pkg::HOUR_MAX);
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    if (!s.key_lock && !key_levels[3])
                    begin
                        r = cdt_pkg::debounce_step(s.debounce_count, cfg.debounce_polls);
                        s.debounce_count = r.count;
                        s.key_lock = r.hit;
                        if (r.hit)
                        begin
                            s.mode = cdt_pkg::mode_t'(s.mode + 2'd1);
                            if (s.mode == cdt_pkg::MODE_NONE)
                            begin
                                s.blink_enable = 1'b0;
                                s.blank_flags  = 3'b000;
                            end
                        end
                    end
                    if (s.mode != cdt_pkg::MODE_NONE && !s.run_flag)
                    begin
                        s.blink_enable = 1'b1;
                        s.blank_flags  = s.blank_flags & cdt_pkg::mode_mask(s.mode);
                    end
                    if (key_levels == 4'hf)
                    begin
                        s.debounce_count = 8'd0;
                        s.key_lock       = 1'b0;
                    end
                    if (cdt_pkg::time_is_zero(s))
                    begin
                        s.run_flag = 1'b0;
                    end
                end
                cdt_pkg::OP_BASE_TICK:
                begin
                    if (s.run_flag)
                    begin
                        if ({1'b0, s.second_prescale} + 9'd1 < {1'b0, cfg.ticks_per_second})
                        begin
                            s.second_prescale = s.second_prescale + 8'd1;
                        end
                        else
                        begin
                            s.second_prescale = 8'd0;
                            if (cdt_pkg::time_is_zero(s))
                            begin
                                s.run_flag = 1'b0;
                            end
                            else
                            begin
                                if (s.sec_count != 6'd0)
                                begin
                                    s.sec_count = s.sec_count - 6'd1;
                                end
                                else
                                begin
                                    s.sec_count = 6'(cdt_pkg::SEC_MAX);
                                    if (s.min_count != 6'd0)
                                    begin
                                        s.min_count = s.min_count - 6'd1;
                                    end
                                    else
                                    begin
                                        s.min_count  = 6'(cdt_pkg::MIN_MAX);
                                        s.hour_count = cdt_pkg::wrap_dec(s.hour_count,
                                                                         cdt_pkg::HOUR_MAX);
                                    end
                                end
                                if (cdt_pkg::time_is_zero(s))
                                begin
                                    s.run_flag = 1'b0;
                                end
                            end
                        end
                    end
                end
                cdt_pkg::OP_BLINK_TICK:
                begin
                    if (s.blink_enable)
                    begin
                        if ({1'b0, s.blink_prescale} + 9'd1 < {1'b0, cfg.blink_divide})
                        begin
                            s.blink_prescale = s.blink_prescale + 8'd1;
                        end
                        else
                        begin
                            s.blink_prescale = 8'd0;
                            s.blank_flags    = s.blank_flags ^ cdt_pkg::mode_mask(s.mode);
                        end
                    end
                end
                cdt_pkg::OP_SCAN:
                begin
                end
                default:
                begin
                end
            endcase
        end
        state_next = s;
    end

    `CDT_ASSERT_IMPLIES(a_lock_clears_count, clk, rst_n, state_reg.key_lock,
                        state_reg.debounce_count == 8'd0, "key lock held with nonzero debounce count")
    `CDT_ASSERT_IMPLIES(a_blank_needs_blink, clk, rst_n, !state_reg.blink_enable,
                        state_reg.blank_flags == 3'b000, "field blanked while blinking is off")
    `CDT_ASSERT_ALWAYS(a_time_in_range, clk, rst_n,
                       state_reg.sec_count <= 6'd59 && state_reg.min_count <= 6'd59
                       && state_reg.hour_count <= 7'd99, "time field out of range")
    `CDT_ASSERT_IMPLIES(a_run_nonzero, clk, rst_n, state_reg.run_flag,
                        !cdt_pkg::time_is_zero(state_reg), "running with zero time")

endmodule

@@ rtl/core/cdt_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_scan
// Seven-segment pattern of one scanned digit position, with field blanking.
// ----------------------------------------------------------------------------
module cdt_scan
(
    input  cdt_pkg::timer_state_t  st,
    input  logic [2:0]             digit_index,
    output logic [7:0]             segments
);

    logic [6:0]        value;
    logic              use_tens;
    logic              blanked;
    logic              dash;
    cdt_pkg::decimal_t dec;

    always_comb
    begin
        value    = 7'd0;
        use_tens = 1'b0;
        blanked  = 1'b0;
        dash     = 1'b0;
        unique case (digit_index)
            cdt_pkg::DIG_SEC_ONES, cdt_pkg::DIG_SEC_TENS:
            begin
                value    = {1'b0, st.sec_count};
                use_tens = (digit_index == cdt_pkg::DIG_SEC_TENS);
                blanked  = st.blank_flags[0];
            end
            cdt_pkg::DIG_MIN_ONES, cdt_pkg::DIG_MIN_TENS:
            begin
                value    = {1'b0, st.min_count};
                use_tens = (digit_index == cdt_pkg::DIG_MIN_TENS);
                blanked  = st.blank_flags[1];
            end
            cdt_pkg::DIG_HOUR_ONES, cdt_pkg::DIG_HOUR_TENS:
            begin
                value    = st.hour_count;
                use_tens = (digit_index == cdt_pkg::DIG_HOUR_TENS);
                blanked  = st.blank_flags[2];
            end
            cdt_pkg::DIG_DASH_LO, cdt_pkg::DIG_DASH_HI:
            begin
                dash = 1'b1;
            end
            default:
            begin
            end
        endcase

        dec = cdt_pkg::split_decimal(value);

        // The separators ignore blanking.
        if (dash)
        begin
            segments = cdt_pkg::SEG_DASH;
        end
        else if (blanked)
        begin
            segments = 8'h00;
        end
        else
        begin
            segments = cdt_pkg::seg_code(use_tens ? dec.tens : dec.ones);
        end
    end

endmodule

@@ rtl/core/countdown_timer_with_key_edit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_with_key_edit_top
// Hours:minutes:seconds countdown timer with four-key editing and display scan.
// ----------------------------------------------------------------------------
// Each request on in_ch carries one event: a key poll with the four active-low
// key levels, a base tick, a blink tick or a display scan of one digit
// position. Every event yields exactly one request on out_ch holding the time,
// the running flag and the edit mode as they stand after the event; segments
// carries the digit pattern for a scan and is zero for the other events.
// The event is decoded and the state updated in the cycle it is accepted, and
// the result sits in an output register, so the result appears in the cycle
// after acceptance. One event can be accepted in every cycle: in_ch.ready is
// high whenever the output register is empty or is being emptied in the same
// cycle, so a stalled receiver holds the result steady and in_ch waits only
// for that one register. Reset clears the time, the flags, the prescalers and
// the debounce state, loads the three configuration registers with their
// defaults and empties the output register. Configuration is written through
// cfg_we, cfg_index and cfg_wdata, by the user only while no event is in flight;
// the block does not enforce this. An index beyond the register list is ignored.
// ----------------------------------------------------------------------------
module countdown_timer_with_key_edit_top
(
    input  logic       clk,
    input  logic       rst_n,
    cdt_in_if.sink     in_ch,
    cdt_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    cdt_pkg::cfg_t         cfg_reg;
    cdt_pkg::timer_state_t state_next;
    cdt_pkg::result_t      result_reg;
    cdt_pkg::result_t      result_next;
    cdt_pkg::op_t          op;
    logic                  out_valid_reg;
    logic                  accept;
    logic [7:0]            scan_seg;

    // The register ahead of the receiver frees up whenever it is taken.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign op          = cdt_pkg::op_t'(in_ch.opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= cdt_pkg::TICKS_PER_SECOND_RST;
            cfg_reg.blink_divide     <= cdt_pkg::BLINK_DIVIDE_RST;
            cfg_reg.debounce_polls   <= cdt_pkg::DEBOUNCE_POLLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cdt_pkg::CFG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_wdata;
                cdt_pkg::CFG_BLINK_DIVIDE:     cfg_reg.blink_divide     <= cfg_wdata;
                cdt_pkg::CFG_DEBOUNCE_POLLS:   cfg_reg.debounce_polls   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Time, flags, prescalers and debounce state, updated once per accepted event.
    cdt_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (accept),
        .op         (op),
        .key_levels (in_ch.key_levels),
        .cfg        (cfg_reg),
        .state_next (state_next)
    );

    // A scan leaves the state alone, so the next state is also the one shown.
    cdt_scan u_scan
    (
        .st          (state_next),
        .digit_index (in_ch.digit_index),
        .segments    (scan_seg)
    );

    always_comb
    begin
        result_next.seconds   = state_next.sec_count;
        result_next.minutes   = state_next.min_count;
        result_next.hours     = state_next.hour_count;
        result_next.running   = state_next.run_flag;
        result_next.edit_mode = state_next.mode;
        result_next.segments  = (op == cdt_pkg::OP_SCAN) ? scan_seg : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.seconds   = result_reg.seconds;
    assign out_ch.minutes   = result_reg.minutes;
    assign out_ch.hours     = result_reg.hours;
    assign out_ch.running   = result_reg.running;
    assign out_ch.edit_mode = result_reg.edit_mode;
    assign out_ch.segments  = result_reg.segments;

endmodule
